// ===== rtl/tps_pkg.sv =====
package tps_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_REGS = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_C = 3'd5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SHADE = 1'b1;

	localparam int STORE_DEPTH = 65536;
	localparam int STORE_AW = 16;
	localparam int TEXEL_W = 24;

	// quotient bits of the texture coordinate (16 integer, 8 fraction)
	localparam int DIV_N = 24;
	localparam int WGT_W = 34;

	typedef struct packed {
		logic command;
		logic signed [11:0] pixel_x;
		logic signed [11:0] pixel_y;
		logic [15:0] texel_index;
		logic [23:0] texel_color;
	} in_item_t;

	typedef struct packed {
		logic signed [11:0] out_x;
		logic signed [11:0] out_y;
		logic write_pixel;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_item_t;

	typedef struct packed {
		logic command;
		logic draw;
		logic [11:0] px;
		logic [11:0] py;
		logic [15:0] index;
		logic [23:0] color;
	} side_t;

endpackage

// ===== rtl/tps_stream_if.sv =====
interface tps_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/tps_ram.sv =====
module tps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic en,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr_a,
	input logic [AW-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// ===== rtl/textured_triangle_pixel_shader_unit.sv =====
// channel   | dir | payload                                        | note
// pix_in    | in  | command, pixel_x, pixel_y, texel_index/color   | load or shade
// pix_out   | out | out_x, out_y, write_pixel, red, green, blue    | one per shade
// cfg_*     | in  | cfg_index, cfg_data                            | write only
//
// one item per cycle sustained while the output register is empty or taken
// most of the pipe is the 24-stage coordinate divider, followed by the texture read port
// loads travel the same pipe and write the texture store at the read stage
// the whole pipe holds when the output register is full and not taken
// arst_n clears valid bits and config registers; data registers and the texture store are not cleared
module textured_triangle_pixel_shader_unit #(
	parameter int TEX_W = 256,
	parameter int TEX_H = 256,
	parameter int SCREEN_W = 1024,
	parameter int SCREEN_H = 1024
) (
	input logic clk,
	input logic arst_n,
	tps_stream_if.sink pix_in,
	tps_stream_if.source pix_out,
	input logic cfg_write,
	input logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tps_pkg::*;

	localparam int XW = $clog2(TEX_W);
	localparam int YW = $clog2(TEX_H);

	logic en;
	logic [31:0] regs_q [NUM_REGS];

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCREEN_A: regs_q[0] <= cfg_data;
				REG_SCREEN_B: regs_q[1] <= cfg_data;
				REG_SCREEN_C: regs_q[2] <= cfg_data;
				REG_TEX_A: regs_q[3] <= cfg_data;
				REG_TEX_B: regs_q[4] <= cfg_data;
				REG_TEX_C: regs_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [16:0] ax, ay, bx, by, cx, cy;
	assign ax = 17'($signed(regs_q[0][15:0]));
	assign ay = 17'($signed(regs_q[0][31:16]));
	assign bx = 17'($signed(regs_q[1][15:0]));
	assign by = 17'($signed(regs_q[1][31:16]));
	assign cx = 17'($signed(regs_q[2][15:0]));
	assign cy = 17'($signed(regs_q[2][31:16]));

	// stage 1: input register
	logic v_s1;
	side_t sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pix_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.command <= pix_in.data.command;
			sb_s1.draw <= 1'b0;
			sb_s1.px <= pix_in.data.pixel_x;
			sb_s1.py <= pix_in.data.pixel_y;
			sb_s1.index <= pix_in.data.texel_index;
			sb_s1.color <= pix_in.data.texel_color;
		end
	end

	// stage 2: edge products
	logic signed [16:0] px1, py1, bax, cay, cax, bay, pax, pay;
	assign px1 = 17'($signed(sb_s1.px));
	assign py1 = 17'($signed(sb_s1.py));
	assign bax = bx - ax;
	assign cay = cy - ay;
	assign cax = cx - ax;
	assign bay = by - ay;
	assign pax = px1 - ax;
	assign pay = py1 - ay;

	logic v_s2;
	side_t sb_s2;
	logic signed [33:0] pd1_s2, pd2_s2, pv1_s2, pv2_s2, pw1_s2, pw2_s2;
	logic onscr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2 <= sb_s1;
			pd1_s2 <= bax * cay;
			pd2_s2 <= cax * bay;
			pv1_s2 <= pax * cay;
			pv2_s2 <= cax * pay;
			pw1_s2 <= bax * pay;
			pw2_s2 <= pax * bay;
			onscr_s2 <= !sb_s1.px[11] && !sb_s1.py[11]
				&& (32'(signed'(sb_s1.px)) < SCREEN_W)
				&& (32'(signed'(sb_s1.py)) < SCREEN_H);
		end
	end

	// stage 3: determinant and two numerators
	logic v_s3, onscr_s3;
	side_t sb_s3;
	logic signed [34:0] det_s3, nv_s3, nw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= sb_s2;
			onscr_s3 <= onscr_s2;
			det_s3 <= 35'(pd1_s2) - 35'(pd2_s2);
			nv_s3 <= 35'(pv1_s2) - 35'(pv2_s2);
			nw_s3 <= 35'(pw1_s2) - 35'(pw2_s2);
		end
	end

	// stage 4: third numerator
	logic v_s4, onscr_s4;
	side_t sb_s4;
	logic signed [35:0] det_s4, nu_s4, nv_s4, nw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4 <= sb_s3;
			onscr_s4 <= onscr_s3;
			det_s4 <= 36'(det_s3);
			nv_s4 <= 36'(nv_s3);
			nw_s4 <= 36'(nw_s3);
			nu_s4 <= 36'(det_s3) - 36'(nv_s3) - 36'(nw_s3);
		end
	end

	// stage 5: sign fix and inside test
	logic signed [35:0] det_f, nu_f, nv_f, nw_f;
	logic in_tri;
	side_t sb_d4;
	always_comb begin
		if (det_s4[35]) begin
			det_f = -det_s4;
			nu_f = -nu_s4;
			nv_f = -nv_s4;
			nw_f = -nw_s4;
		end else begin
			det_f = det_s4;
			nu_f = nu_s4;
			nv_f = nv_s4;
			nw_f = nw_s4;
		end
		in_tri = (det_s4 != '0) && (nu_f > 0) && (nv_f > 0) && (nw_f > 0);
		sb_d4 = sb_s4;
		sb_d4.draw = in_tri && onscr_s4;
	end

	logic v_s5;
	side_t sb_s5;
	logic [WGT_W-1:0] d_s5, wu_s5, wv_s5, ww_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5 <= sb_d4;
			d_s5 <= det_f[WGT_W-1:0];
			wu_s5 <= nu_f[WGT_W-1:0];
			wv_s5 <= nv_f[WGT_W-1:0];
			ww_s5 <= nw_f[WGT_W-1:0];
		end
	end

	// stage 6: weight times texture coordinate
	logic v_s6;
	side_t sb_s6;
	logic [WGT_W-1:0] d_s6;
	logic [49:0] mu0_s6, mu1_s6, mu2_s6, mv0_s6, mv1_s6, mv2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6 <= sb_s5;
			d_s6 <= d_s5;
			mu0_s6 <= 50'(wu_s5) * 50'(regs_q[3][15:0]);
			mu1_s6 <= 50'(wv_s5) * 50'(regs_q[4][15:0]);
			mu2_s6 <= 50'(ww_s5) * 50'(regs_q[5][15:0]);
			mv0_s6 <= 50'(wu_s5) * 50'(regs_q[3][31:16]);
			mv1_s6 <= 50'(wv_s5) * 50'(regs_q[4][31:16]);
			mv2_s6 <= 50'(ww_s5) * 50'(regs_q[5][31:16]);
		end
	end

	logic [51:0] sum_u, sum_v;
	assign sum_u = 52'(mu0_s6) + 52'(mu1_s6) + 52'(mu2_s6);
	assign sum_v = 52'(mv0_s6) + 52'(mv1_s6) + 52'(mv2_s6);

	// divider: one quotient bit per stage, stage 0 holds the sums
	logic v_sd [DIV_N+1];
	side_t sb_sd [DIV_N+1];
	logic [WGT_W-1:0] d_sd [DIV_N+1];
	logic [WGT_W-1:0] ru_sd [DIV_N+1];
	logic [WGT_W-1:0] rv_sd [DIV_N+1];
	logic [DIV_N-1:0] nu_sd [DIV_N+1];
	logic [DIV_N-1:0] nv_sd [DIV_N+1];
	logic [DIV_N-1:0] qu_sd [DIV_N+1];
	logic [DIV_N-1:0] qv_sd [DIV_N+1];

	logic [WGT_W-1:0] ru_nx [DIV_N];
	logic [WGT_W-1:0] rv_nx [DIV_N];
	logic gu_nx [DIV_N];
	logic gv_nx [DIV_N];

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			logic [WGT_W:0] tu, tv, dd;
			dd = {1'b0, d_sd[k]};
			tu = {ru_sd[k], nu_sd[k][DIV_N-1]};
			tv = {rv_sd[k], nv_sd[k][DIV_N-1]};
			gu_nx[k] = tu >= dd;
			gv_nx[k] = tv >= dd;
			ru_nx[k] = gu_nx[k] ? WGT_W'(tu - dd) : tu[WGT_W-1:0];
			rv_nx[k] = gv_nx[k] ? WGT_W'(tv - dd) : tv[WGT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_N; k++) v_sd[k] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s6;
			for (int k = 0; k < DIV_N; k++) v_sd[k+1] <= v_sd[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sd[0] <= sb_s6;
			d_sd[0] <= d_s6;
			ru_sd[0] <= sum_u[WGT_W+15:16];
			rv_sd[0] <= sum_v[WGT_W+15:16];
			nu_sd[0] <= {sum_u[15:0], 8'h00};
			nv_sd[0] <= {sum_v[15:0], 8'h00};
			qu_sd[0] <= '0;
			qv_sd[0] <= '0;
			for (int k = 0; k < DIV_N; k++) begin
				sb_sd[k+1] <= sb_sd[k];
				d_sd[k+1] <= d_sd[k];
				ru_sd[k+1] <= ru_nx[k];
				rv_sd[k+1] <= rv_nx[k];
				nu_sd[k+1] <= {nu_sd[k][DIV_N-2:0], 1'b0};
				nv_sd[k+1] <= {nv_sd[k][DIV_N-2:0], 1'b0};
				qu_sd[k+1] <= {qu_sd[k][DIV_N-2:0], gu_nx[k]};
				qv_sd[k+1] <= {qv_sd[k][DIV_N-2:0], gv_nx[k]};
			end
		end
	end

	// stage 8: texel neighbours, clamped at the texture edge
	logic [15:0] iu, iv;
	assign iu = qu_sd[DIV_N][DIV_N-1:8];
	assign iv = qv_sd[DIV_N][DIV_N-1:8];

	logic v_s8;
	side_t sb_s8;
	logic [XW-1:0] x0_s8, x1_s8;
	logic [YW-1:0] y0_s8, y1_s8;
	logic [7:0] fa_s8, fb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_sd[DIV_N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s8 <= sb_sd[DIV_N];
			fa_s8 <= qu_sd[DIV_N][7:0];
			fb_s8 <= qv_sd[DIV_N][7:0];
			if (32'(iu) >= 32'(TEX_W - 1)) begin
				x0_s8 <= XW'(TEX_W - 1);
				x1_s8 <= XW'(TEX_W - 1);
			end else begin
				x0_s8 <= iu[XW-1:0];
				x1_s8 <= iu[XW-1:0] + XW'(1);
			end
			if (32'(iv) >= 32'(TEX_H - 1)) begin
				y0_s8 <= YW'(TEX_H - 1);
				y1_s8 <= YW'(TEX_H - 1);
			end else begin
				y0_s8 <= iv[YW-1:0];
				y1_s8 <= iv[YW-1:0] + YW'(1);
			end
		end
	end

	logic [31:0] row0, row1;
	logic [STORE_AW-1:0] a00, a01, a10, a11;
	assign row0 = 32'(y0_s8) * 32'(TEX_W);
	assign row1 = 32'(y1_s8) * 32'(TEX_W);
	assign a00 = STORE_AW'(row0 + 32'(x0_s8));
	assign a01 = STORE_AW'(row1 + 32'(x0_s8));
	assign a10 = STORE_AW'(row0 + 32'(x1_s8));
	assign a11 = STORE_AW'(row1 + 32'(x1_s8));

	// loads write here so they stay in order with the reads
	logic st_we;
	assign st_we = en && v_s8 && (sb_s8.command == CMD_LOAD);

	logic [TEXEL_W-1:0] t00, t01, t10, t11;

	tps_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_lo (
		.clk(clk), .en(en), .we(st_we),
		.waddr(sb_s8.index), .wdata(sb_s8.color),
		.raddr_a(a00), .raddr_b(a01),
		.rdata_a(t00), .rdata_b(t01)
	);

	tps_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_hi (
		.clk(clk), .en(en), .we(st_we),
		.waddr(sb_s8.index), .wdata(sb_s8.color),
		.raddr_a(a10), .raddr_b(a11),
		.rdata_a(t10), .rdata_b(t11)
	);

	// stage 9: texels read
	logic v_s9;
	side_t sb_s9;
	logic [7:0] fa_s9, fb_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s9 <= sb_s8;
			fa_s9 <= fa_s8;
			fb_s9 <= fb_s8;
		end
	end

	// stage 10: vertical lerps, floored
	logic [7:0] lc [3];
	logic [7:0] rc [3];
	always_comb begin
		logic [8:0] wb0, wb1;
		logic [17:0] sl, sr;
		wb1 = {1'b0, fb_s9};
		wb0 = 9'd256 - wb1;
		for (int k = 0; k < 3; k++) begin
			sl = 18'(t00[16-8*k +: 8]) * 18'(wb0) + 18'(t01[16-8*k +: 8]) * 18'(wb1);
			sr = 18'(t10[16-8*k +: 8]) * 18'(wb0) + 18'(t11[16-8*k +: 8]) * 18'(wb1);
			lc[k] = sl[15:8];
			rc[k] = sr[15:8];
		end
	end

	logic v_s10;
	side_t sb_s10;
	logic [7:0] fa_s10;
	logic [7:0] l_s10 [3];
	logic [7:0] r_s10 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s10 <= sb_s9;
			fa_s10 <= fa_s9;
			for (int k = 0; k < 3; k++) begin
				l_s10[k] <= lc[k];
				r_s10[k] <= rc[k];
			end
		end
	end

	// horizontal lerp, rounded half up
	logic [7:0] hc [3];
	always_comb begin
		logic [8:0] wa0, wa1;
		logic [17:0] sh;
		wa1 = {1'b0, fa_s10};
		wa0 = 9'd256 - wa1;
		for (int k = 0; k < 3; k++) begin
			sh = 18'(l_s10[k]) * 18'(wa0) + 18'(r_s10[k]) * 18'(wa1) + 18'd128;
			hc[k] = sb_s10.draw ? sh[15:8] : 8'h00;
		end
	end

	// output register
	logic out_valid_q;
	out_item_t out_q;

	assign en = !out_valid_q || pix_out.ready;
	assign pix_in.ready = en;
	assign pix_out.valid = out_valid_q;
	assign pix_out.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_s10 && (sb_s10.command == CMD_SHADE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.out_x <= sb_s10.px;
			out_q.out_y <= sb_s10.py;
			out_q.write_pixel <= sb_s10.draw;
			out_q.red <= hc[0];
			out_q.green <= hc[1];
			out_q.blue <= hc[2];
		end
	end
endmodule
